FILE: design/ttip_pkg.sv
// Package for the text-to-integer parser: field widths, character codes,
// base constants, parse phases, register indexes and the classified-character record.
// No dependencies; every other design file imports it.
package ttip_pkg;

   // Field widths of the transaction payloads.
   localparam int CH_BITS       = 8;
   localparam int VALUE_BITS    = 64;
   localparam int CONSUMED_BITS = 16;
   localparam int RADIX_BITS    = 6;

   // Defaults of the top-level parameters.
   localparam int WORD_BITS_DEFAULT  = 64;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Entries of the queue between the classifier and the parse engine.
   localparam int QUEUE_DEPTH = 4;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic {
      REG_RADIX  = 1'b0,
      REG_SIGNED = 1'b1
   } csr_reg_type;

   // Character codes.
   localparam logic [CH_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CH_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CH_BITS-1:0] CHAR_CR      = 8'h0d;
   localparam logic [CH_BITS-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [CH_BITS-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CH_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CH_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CH_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CH_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CH_BITS-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CH_BITS-1:0] CHAR_LOWER_X = 8'h78;

   // Digit values.
   localparam logic [CH_BITS-1:0] DIGIT_ALPHA = 8'd10;
   localparam logic [CH_BITS-1:0] DIGIT_NONE  = 8'hff;

   // Bases.
   localparam logic [RADIX_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [RADIX_BITS-1:0] BASE_MIN  = 6'd2;
   localparam logic [RADIX_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [RADIX_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [RADIX_BITS-1:0] BASE_HEX  = 6'd16;
   localparam logic [RADIX_BITS-1:0] BASE_MAX  = 6'd36;

   // Parse phases of the engine.
   typedef enum logic [2:0] {
      PH_WS,
      PH_START,
      PH_ZERO,
      PH_XPREFIX,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // One classified character as it travels through the queue.
   typedef struct packed {
      logic [CH_BITS-1:0] digit;
      logic               space;
      logic               plus;
      logic               minus;
      logic               xchar;
      logic               last;
   } class_type;

endpackage

FILE: design/ttip_if.sv
// Channel interfaces of the text-to-integer parser: the character channel and
// the result channel, each with valid/ready and its payload. Depends on ttip_pkg.
interface ttip_req_if;
   import ttip_pkg::*;
   logic               valid;
   logic               ready;
   logic [CH_BITS-1:0] ch;
   logic               last;
   modport source (output valid, ch, last, input ready);
   modport sink   (input valid, ch, last, output ready);
endinterface

interface ttip_rsp_if;
   import ttip_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [VALUE_BITS-1:0]    value;
   logic [CONSUMED_BITS-1:0] consumed;
   logic                     overflow;
   modport source (output valid, value, consumed, overflow, input ready);
   modport sink   (input valid, value, consumed, overflow, output ready);
endinterface

FILE: design/ttip_front.sv
// Front part of the parser: accepts character transactions and classifies each
// character (digit value, whitespace, signs, x) for the queue. Depends on ttip_pkg, ttip_if.
module ttip_front (
   ttip_req_if.sink             req_bus,
   input  logic                 queue_full,
   output logic                 push,
   output ttip_pkg::class_type  push_data
);
   import ttip_pkg::*;

   // Accept whenever the queue has room.
   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // Classify the character. Every byte at or above 'A' maps to a letter digit,
   // so punctuation above 'Z' gets a value that no base accepts.
   always_comb begin
      push_data       = '0;
      push_data.last  = req_bus.last;
      if (req_bus.ch >= CHAR_LOWER_A) begin
         push_data.digit = req_bus.ch - CHAR_LOWER_A + DIGIT_ALPHA;
      end else if (req_bus.ch >= CHAR_UPPER_A) begin
         push_data.digit = req_bus.ch - CHAR_UPPER_A + DIGIT_ALPHA;
      end else if (req_bus.ch >= CHAR_ZERO && req_bus.ch <= CHAR_NINE) begin
         push_data.digit = req_bus.ch - CHAR_ZERO;
      end else begin
         push_data.digit = DIGIT_NONE;
      end
      push_data.space = (req_bus.ch == CHAR_SPACE) ||
                        (req_bus.ch >= CHAR_TAB && req_bus.ch <= CHAR_CR);
      push_data.plus  = (req_bus.ch == CHAR_PLUS);
      push_data.minus = (req_bus.ch == CHAR_MINUS);
      push_data.xchar = (req_bus.ch == CHAR_LOWER_X) || (req_bus.ch == CHAR_UPPER_X);
   end

endmodule

FILE: design/ttip_queue.sv
// Short queue of classified characters between the front and the parse engine,
// so that each side stalls on its own. Depends on ttip_pkg.
module ttip_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ttip_pkg::class_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output ttip_pkg::class_type  head
);
   import ttip_pkg::*;

   localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   class_type             mem_ff [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/ttip_back.sv
// Back part of the parser: the parse engine (phase machine, base selection,
// multiply-add accumulator, counters) and the result register. Depends on ttip_pkg, ttip_if.
module ttip_back #(
   parameter int WORD_BITS  = ttip_pkg::WORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  ttip_pkg::class_type               head,
   output logic                              pop,
   input  logic [ttip_pkg::RADIX_BITS-1:0]   radix,
   input  logic                              signed_mode,
   ttip_rsp_if.source                        rsp_bus
);
   import ttip_pkg::*;

   localparam int SUM_BITS = WORD_BITS + RADIX_BITS + 1;
   localparam logic [WORD_BITS-1:0]  WORD_ONES = '1;
   localparam logic [WORD_BITS-1:0]  LIM_NEG   = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0]  LIM_POS   = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Parse state.
   phase_type              phase_ff, phase_in;
   logic [RADIX_BITS-1:0]  base_ff, base_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_BITS-1:0]  pos_ff, pos_in;
   logic [COUNT_BITS-1:0]  stop_ff, stop_in;
   logic                   ovf_ff, ovf_in;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0]   out_mag_ff;
   logic [COUNT_BITS-1:0]  out_stop_ff;
   logic                   out_ovf_ff;
   logic                   out_neg_ff;
   logic                   out_sgn_ff;

   logic                   in_ws;
   logic                   ws_hold;
   logic                   zero_prefix;
   logic                   check_digit;
   logic [RADIX_BITS-1:0]  digit_base;
   logic                   digit_ok;
   logic [SUM_BITS-1:0]    sum;
   logic                   sum_over;
   logic [COUNT_BITS-1:0]  pos_inc;
   logic                   emit;

   // A final character waits for the result register to be free.
   assign pop  = head_valid && (!head.last || !out_valid_ff || rsp_bus.ready);
   assign emit = pop && head.last;

   assign pos_inc = (pos_ff == COUNT_MAX) ? pos_ff : pos_ff + 1'b1;

   // Whitespace and sign handling happen only in the leading phase.
   assign in_ws   = (phase_ff == PH_WS);
   assign ws_hold = in_ws && (head.space || head.plus || (head.minus && signed_mode));
   assign zero_prefix = (head.digit == '0) && (radix == BASE_AUTO || radix == BASE_HEX);

   // Base for this character and whether it is tested as a digit.
   always_comb begin
      digit_base  = base_ff;
      check_digit = 1'b0;
      case (phase_ff)
         PH_WS, PH_START: begin
            if (!ws_hold && !zero_prefix) begin
               digit_base  = (radix == BASE_AUTO) ? BASE_DEC : radix;
               check_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (!head.xchar) begin
               digit_base  = (base_ff == BASE_AUTO) ? BASE_OCT : base_ff;
               check_digit = 1'b1;
            end
         end
         PH_XPREFIX, PH_DIGITS: begin
            check_digit = 1'b1;
         end
         default: begin
            check_digit = 1'b0;
         end
      endcase
   end

   // Digit test and multiply-add; the product overflows when it does not fit the word.
   assign digit_ok = (digit_base >= BASE_MIN) && (digit_base <= BASE_MAX) &&
                     ({{(CH_BITS-RADIX_BITS){1'b0}}, digit_base} > head.digit);
   assign sum      = SUM_BITS'(acc_ff) * SUM_BITS'(digit_base) + SUM_BITS'(head.digit);
   assign sum_over = |sum[SUM_BITS-1:WORD_BITS];

   // Next parse state for the character at the queue head.
   always_comb begin
      phase_in = phase_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      ovf_in   = ovf_ff;
      if (pop) begin
         pos_in = pos_inc;
         case (phase_ff)
            PH_WS, PH_START: begin
               if (in_ws && head.space) begin
                  phase_in = PH_WS;
               end else if (in_ws && head.plus) begin
                  phase_in = PH_START;
               end else if (in_ws && head.minus && signed_mode) begin
                  neg_in   = 1'b1;
                  phase_in = PH_START;
               end else if (zero_prefix) begin
                  base_in  = radix;
                  stop_in  = pos_inc;
                  phase_in = PH_ZERO;
               end else begin
                  base_in  = digit_base;
               end
            end
            PH_ZERO: begin
               if (head.xchar) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_XPREFIX;
               end else begin
                  base_in  = digit_base;
               end
            end
            default: begin
               base_in = base_ff;
            end
         endcase
         if (check_digit) begin
            if (digit_ok) begin
               if (!ovf_ff) begin
                  if (sum_over) begin
                     ovf_in = 1'b1;
                     acc_in = WORD_ONES;
                  end else begin
                     acc_in = sum[WORD_BITS-1:0];
                  end
               end
               stop_in  = pos_inc;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Parse state registers; a final character returns the engine to its start.
   always_ff @(posedge clock) begin
      if (reset || emit) begin
         phase_ff <= PH_WS;
         base_ff  <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         pos_ff   <= '0;
         stop_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Result register handshake.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Raw result fields, with signed_mode sampled at emission.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_mag_ff  <= acc_in;
         out_stop_ff <= stop_in;
         out_ovf_ff  <= ovf_in;
         out_neg_ff  <= neg_in;
         out_sgn_ff  <= signed_mode;
      end
   end

   // Range clamping and sign application on the stored result.
   always_comb begin
      logic [WORD_BITS-1:0] val;
      logic                 ovf;
      val = out_mag_ff;
      ovf = out_ovf_ff;
      if (out_sgn_ff) begin
         if (out_neg_ff) begin
            if (out_ovf_ff || out_mag_ff > LIM_NEG) begin
               ovf = 1'b1;
               val = LIM_NEG;
            end else begin
               val = '0 - out_mag_ff;
            end
         end else if (out_ovf_ff || out_mag_ff > LIM_POS) begin
            ovf = 1'b1;
            val = LIM_POS;
         end
      end else if (out_ovf_ff) begin
         val = WORD_ONES;
      end
      rsp_bus.value    = VALUE_BITS'(val);
      rsp_bus.overflow = ovf;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.consumed = CONSUMED_BITS'(out_stop_ff);

endmodule

FILE: design/text_to_integer_parser_unit.sv
// Top level of the text-to-integer parser: configuration registers, front,
// queue and parse engine. Depends on ttip_pkg, ttip_if, ttip_front, ttip_queue, ttip_back.
//
// The parser takes one character per transaction and emits one result on the
// character marked last: the value (strtol/strtoul style, with optional sign,
// automatic base detection and 0x prefix), the count of consumed characters and
// an overflow flag. It accepts one character per clock cycle: the front
// classifies the character, a four-entry queue holds it, and the engine folds
// it into the accumulator with one multiply-add by the base, which is the
// loop that sets this rate. An accepted final character passes the queue and
// then the result register before its result appears.
// The engine stalls only when a final character finds the result register still
// occupied; the queue then fills and the character channel deasserts ready.
// Registers: radix at byte address 0 (0 selects automatic base detection) and
// signed_mode at byte address 4; write them only while the parser is idle.
module text_to_integer_parser_unit #(
   parameter int WORD_BITS  = ttip_pkg::WORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ttip_req_if.sink                             req_bus,
   ttip_rsp_if.source                           rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ttip_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ttip_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ttip_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import ttip_pkg::*;

   logic [RADIX_BITS-1:0] radix_ff;
   logic                  signed_mode_ff;
   csr_reg_type           reg_sel;
   logic                  csr_write;

   logic                  push;
   class_type             push_data;
   logic                  queue_full;
   logic                  pop;
   logic                  head_valid;
   class_type             head;

   // Configuration registers.
   assign pready    = 1'b1;
   assign reg_sel   = csr_reg_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= BASE_AUTO;
         signed_mode_ff <= 1'b1;
      end else if (csr_write) begin
         case (reg_sel)
            REG_RADIX:  radix_ff       <= pwdata[RADIX_BITS-1:0];
            REG_SIGNED: signed_mode_ff <= pwdata[0];
            default:    radix_ff       <= radix_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RADIX:  prdata = CSR_DATA_BITS'(radix_ff);
         REG_SIGNED: prdata = CSR_DATA_BITS'(signed_mode_ff);
         default:    prdata = '0;
      endcase
   end

   // Front: accept and classify.
   ttip_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Queue between front and engine.
   ttip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Parse engine and result register.
   ttip_back #(
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .radix       (radix_ff),
      .signed_mode (signed_mode_ff),
      .rsp_bus     (rsp_bus)
   );

endmodule

FILE: design/ttip_checker.sv
// Port-level checks of the text-to-integer parser results, bound to the top level.
// Depends on ttip_pkg and text_to_integer_parser_unit.
module ttip_checker #(
   parameter int WORD_BITS  = ttip_pkg::WORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ttip_pkg::COUNT_BITS_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [ttip_pkg::VALUE_BITS-1:0]      rsp_value,
   input logic [ttip_pkg::CONSUMED_BITS-1:0]   rsp_consumed,
   input logic                                 rsp_overflow
);
   import ttip_pkg::*;

   localparam logic [VALUE_BITS-1:0] WORD_ONES = {VALUE_BITS{1'b1}} >> (VALUE_BITS - WORD_BITS);
   localparam logic [VALUE_BITS-1:0] LIM_NEG   = VALUE_BITS'(1) << (WORD_BITS - 1);
   localparam logic [VALUE_BITS-1:0] LIM_POS   = LIM_NEG - 1'b1;
   localparam bit                    NARROW_COUNT = (COUNT_BITS <= CONSUMED_BITS);

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
                                  $stable(rsp_consumed) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // An overflowed result is one of the clamp values.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_value == WORD_ONES || rsp_value == LIM_NEG || rsp_value == LIM_POS)
      else $error("overflow result is not a clamp value");

   // Without any digit the value is zero.
   a_no_digit: assert property (@(posedge clock) disable iff (reset)
      NARROW_COUNT && rsp_valid && rsp_consumed == '0 |-> rsp_value == '0 && !rsp_overflow)
      else $error("nonzero result without consumed digits");

   // Bits above the word width stay clear.
   a_word_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value & ~WORD_ONES) == '0)
      else $error("result bits above the word width are set");

endmodule

bind text_to_integer_parser_unit ttip_checker #(
   .WORD_BITS  (WORD_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_ttip_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_value    (rsp_bus.value),
   .rsp_consumed (rsp_bus.consumed),
   .rsp_overflow (rsp_bus.overflow)
);
